>>> sv/psl_pkg.sv
`default_nettype none
package psl_pkg;

  // List store size and field widths
  localparam int CAPACITY = 128;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int KIND_W   = 2;

  // Read-back tree: cells per first-level group, and group count
  localparam int GROUP = 16;
  localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Broadcast to every cell for one accepted word
  typedef struct packed {
    logic              ins;   // shift up from pos, write val at pos
    logic              del;   // shift down from pos
    logic              rd;    // drive entry at pos onto the read tree
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } psl_ctrl_t;

endpackage
`default_nettype wire

>>> sv/positional_shift_list.sv
// Ordered list of up to CAPACITY signed 32-bit values. Each input word is
// one operation (insert at a position, delete at a position, read at a
// position, clear) and yields exactly one output word with a status, the
// value read or removed (zero otherwise) and the list length afterwards.
// Errors leave the list untouched; append is insert at position length.
// The block takes one word per clock cycle unless the output stalls: every
// cell of the list shifts in parallel in the cycle the word is accepted. The
// first level of the read-back OR tree across the cells is registered, with
// status and length held beside it; the second level feeds the output
// register directly, and the result waits there until it is taken. A
// stalled output holds the result and backs up into the input through one
// intermediate stage.
`default_nettype none
module positional_shift_list
  import psl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // kind[1:0], position[9:2], value_in[41:10], zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata   // status[1:0], value_out[33:2], length[41:34], zero
);

  kind_t             kind;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] val_in;
  logic              in_acc;

  logic [POS_W-1:0]  count_r;
  logic [POS_W-1:0]  count_nxt;
  status_t           status;
  psl_ctrl_t         ctrl;

  logic              s1_v_r;
  status_t           s1_stat_r;
  logic [POS_W-1:0]  s1_len_r;
  logic              out_v_r;
  status_t           out_stat_r;
  logic [DATA_W-1:0] out_val_r;
  logic [POS_W-1:0]  out_len_r;
  logic [DATA_W-1:0] rd_val;
  logic              adv_out;

  // Unpack the input word
  assign kind   = kind_t'(in_tdata[1:0]);
  assign pos    = in_tdata[9:2];
  assign val_in = in_tdata[41:10];

  // Handshake: output stage frees when empty or being taken
  assign adv_out   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv_out;
  assign in_acc    = in_tvalid && in_tready;

  // Check the operation against the current length
  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    ctrl      = '0;
    ctrl.pos  = pos;
    ctrl.val  = val_in;
    unique case (kind)
      KIND_INSERT: begin
        if (count_r >= CAP_COUNT) begin
          status = ST_FULL;
        end else if (pos > count_r) begin
          status = ST_BADPOS;
        end else begin
          ctrl.ins  = in_acc;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_DELETE: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (pos >= count_r) begin
          status = ST_BADPOS;
        end else begin
          ctrl.del  = in_acc;
          ctrl.rd   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_READ: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (pos >= count_r) begin
          status = ST_BADPOS;
        end else begin
          ctrl.rd = 1'b1;
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  psl_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .ld     (in_acc),
    .rd_val (rd_val)
  );

  // Advance the length and the valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r <= count_nxt;
      end
      if (in_tready) begin
        s1_v_r <= in_acc;
      end
      if (adv_out) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Hold status and length beside the tree's first level
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_stat_r <= status;
      s1_len_r  <= count_nxt;
    end
  end

  // Load the output register from the finished tree
  always_ff @(posedge clk) begin
    if (adv_out && s1_v_r) begin
      out_stat_r <= s1_stat_r;
      out_val_r  <= rd_val;
      out_len_r  <= s1_len_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_len_r, out_val_r, out_stat_r};

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_COUNT)
    else $error("list length above capacity");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[41:34] <= CAP_COUNT))
    else $error("reported length above capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] != ST_OK)) |-> (out_tdata[33:2] == '0))
    else $error("error result carries a value");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (kind == KIND_CLEAR)) |=> (count_r == '0))
    else $error("clear left entries in the list");
`endif

endmodule
`default_nettype wire

>>> sv/psl_cell.sv
`default_nettype none
module psl_cell
  import psl_pkg::*;
(
  input  wire logic              clk,
  input  wire psl_ctrl_t         ctrl,
  input  wire logic [POS_W-1:0]  idx,
  input  wire logic [DATA_W-1:0] left_val,
  input  wire logic [DATA_W-1:0] right_val,
  output logic      [DATA_W-1:0] entry,
  output logic      [DATA_W-1:0] tap
);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic              above;
  logic              at_pos;

  assign above  = (idx > ctrl.pos);
  assign at_pos = (idx == ctrl.pos);

  // Take the lower neighbour on insert, the upper one on delete
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins && above) begin
      entry_nxt = left_val;
    end else if (ctrl.ins && at_pos) begin
      entry_nxt = ctrl.val;
    end else if (ctrl.del && (above || at_pos)) begin
      entry_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  // Drive the old entry onto the read tree when addressed
  assign tap   = (ctrl.rd && at_pos) ? entry_r : '0;

endmodule
`default_nettype wire

>>> sv/psl_chain.sv
`default_nettype none
module psl_chain
  import psl_pkg::*;
(
  input  wire logic              clk,
  input  wire psl_ctrl_t         ctrl,
  input  wire logic              ld,
  output logic      [DATA_W-1:0] rd_val
);

  logic [DATA_W-1:0] entry [CAPACITY];
  logic [DATA_W-1:0] tap   [CAPACITY];
  logic [DATA_W-1:0] part_r   [NGRP];
  logic [DATA_W-1:0] part_nxt [NGRP];

  // Row of cells, each wired to its two neighbours
  for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;

    if (c == 0) begin : g_lo
      assign left_v = '0;
    end else begin : g_lo_n
      assign left_v = entry[c-1];
    end

    if (c == CAPACITY - 1) begin : g_hi
      assign right_v = '0;
    end else begin : g_hi_n
      assign right_v = entry[c+1];
    end

    psl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (POS_W'(c)),
      .left_val  (left_v),
      .right_val (right_v),
      .entry     (entry[c]),
      .tap       (tap[c])
    );
  end

  // First tree level: OR the taps of each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          part_nxt[g] = part_nxt[g] | tap[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      part_r <= part_nxt;
    end
  end

  // Second tree level: OR the group results
  always_comb begin
    rd_val = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_val = rd_val | part_r[g];
    end
  end

endmodule
`default_nettype wire
